// ----- src/ctmt_pkg.sv -----
// shared types, constants and helpers for the control mode takeover coordinator
`timescale 1ns / 1ps

package ctmt_pkg;

	localparam int STICK_BITS = 10;
	localparam int COUNT_BITS = 8;
	localparam int TIME_BITS  = 32;
	localparam int RMS_BITS   = 16;
	localparam int MODE_BITS  = 3;
	localparam int SRC_BITS   = 4;
	localparam int CAP_BITS   = 8;
	localparam int CMD_BITS   = 2;
	localparam int EV_BITS    = 3;
	localparam int IDX_BITS   = 2;
	localparam int CFG_BITS   = 16;

	// modes
	localparam logic [MODE_BITS-1:0] M_DISABLED = 3'd0;
	localparam logic [MODE_BITS-1:0] M_MANUAL   = 3'd1;
	localparam logic [MODE_BITS-1:0] M_AUTO     = 3'd2;
	localparam logic [MODE_BITS-1:0] M_LINE     = 3'd3;
	localparam logic [MODE_BITS-1:0] M_MAINT    = 3'd4;

	// item kinds
	localparam logic [CMD_BITS-1:0] CMD_SAMPLE  = 2'd0;
	localparam logic [CMD_BITS-1:0] CMD_REQUEST = 2'd1;
	localparam logic [CMD_BITS-1:0] CMD_CAP     = 2'd2;

	// events
	localparam logic [EV_BITS-1:0] EV_NONE       = 3'd0;
	localparam logic [EV_BITS-1:0] EV_MANUAL     = 3'd1;
	localparam logic [EV_BITS-1:0] EV_RESTORE_AU = 3'd2;
	localparam logic [EV_BITS-1:0] EV_RESTORE_LN = 3'd3;
	localparam logic [EV_BITS-1:0] EV_DISCONNECT = 3'd4;

	// configuration register indexes
	localparam logic [IDX_BITS-1:0] REG_ENTER   = 2'd0;
	localparam logic [IDX_BITS-1:0] REG_EXIT    = 2'd1;
	localparam logic [IDX_BITS-1:0] REG_CONFIRM = 2'd2;
	localparam logic [IDX_BITS-1:0] REG_RESTORE = 2'd3;

	localparam logic [STICK_BITS-1:0] ENTER_RST   = STICK_BITS'(600);
	localparam logic [STICK_BITS-1:0] EXIT_RST    = STICK_BITS'(200);
	localparam logic [COUNT_BITS-1:0] CONFIRM_RST = COUNT_BITS'(3);
	localparam logic [RMS_BITS-1:0]   RESTORE_RST = RMS_BITS'(2000);

	typedef struct packed {
		logic [STICK_BITS-1:0] enter_thr;
		logic [STICK_BITS-1:0] exit_thr;
		logic [COUNT_BITS-1:0] confirm;
		logic [RMS_BITS-1:0]   restore_ms;
	} cfg_t;

	typedef struct packed {
		logic [CMD_BITS-1:0]   cmd;
		logic                  link_online;
		logic                  sample_ok;
		logic [STICK_BITS-1:0] stick_level;
		logic                  dpad_pressed;
		logic                  macro_held;
		logic                  macro_pressed_edge;
		logic [TIME_BITS-1:0]  time_ms;
		logic [MODE_BITS-1:0]  requested_mode;
		logic [CAP_BITS-1:0]   new_capability;
		logic                  policy_ok;
	} item_t;

	typedef struct packed {
		logic [MODE_BITS-1:0]  mode;
		logic [MODE_BITS-1:0]  recovery;
		logic [TIME_BITS-1:0]  generation;
		logic                  takeover;
		logic [TIME_BITS-1:0]  neutral_start;
		logic                  neutral_timing;
		logic                  stick_latch;
		logic [COUNT_BITS-1:0] confirm_count;
		logic [SRC_BITS-1:0]   capability;
	} state_t;

	typedef struct packed {
		logic [EV_BITS-1:0]   event_res;
		logic                 accepted;
		logic [MODE_BITS-1:0] current_mode;
		logic [MODE_BITS-1:0] saved_recovery_mode;
		logic                 takeover_flag;
		logic [TIME_BITS-1:0] generation_count;
		logic                 policy_issued;
		logic [SRC_BITS-1:0]  policy_enable_mask;
		logic [SRC_BITS-1:0]  policy_qualify_mask;
		logic [TIME_BITS-1:0] policy_generation;
	} result_t;

	// source bit that owns a mode
	function automatic logic [SRC_BITS-1:0] source_of(input logic [MODE_BITS-1:0] mode);
		logic [SRC_BITS-1:0] src;
		case (mode)
			M_MANUAL: src = 4'b0001;
			M_AUTO:   src = 4'b0010;
			M_LINE:   src = 4'b0100;
			M_MAINT:  src = 4'b1000;
			default:  src = 4'b0000;
		endcase
		return src;
	endfunction

endpackage

// ----- src/ctmt_cfg_regs.sv -----
// configuration register bank with its write channel
`timescale 1ns / 1ps

module ctmt_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ctmt_pkg::IDX_BITS-1:0] cfg_index,
	input  logic [ctmt_pkg::CFG_BITS-1:0] cfg_data,
	output ctmt_pkg::cfg_t                cfg
);

	ctmt_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enter_thr  <= ctmt_pkg::ENTER_RST;
			cfg_q.exit_thr   <= ctmt_pkg::EXIT_RST;
			cfg_q.confirm    <= ctmt_pkg::CONFIRM_RST;
			cfg_q.restore_ms <= ctmt_pkg::RESTORE_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				ctmt_pkg::REG_ENTER:   cfg_q.enter_thr  <= cfg_data[ctmt_pkg::STICK_BITS-1:0];
				ctmt_pkg::REG_EXIT:    cfg_q.exit_thr   <= cfg_data[ctmt_pkg::STICK_BITS-1:0];
				ctmt_pkg::REG_CONFIRM: cfg_q.confirm    <= cfg_data[ctmt_pkg::COUNT_BITS-1:0];
				ctmt_pkg::REG_RESTORE: cfg_q.restore_ms <= cfg_data[ctmt_pkg::RMS_BITS-1:0];
				default: ;
			endcase
		end
	end

endmodule

// ----- src/ctmt_step.sv -----
// per-item decision logic: next state and result from the registered item
`timescale 1ns / 1ps

module ctmt_step (
	input  ctmt_pkg::cfg_t    cfg,
	input  ctmt_pkg::state_t  st,
	input  ctmt_pkg::item_t   item,
	output ctmt_pkg::state_t  nx,
	output ctmt_pkg::result_t res
);

	always_comb begin
		logic [ctmt_pkg::EV_BITS-1:0]    ev;
		logic                            acc;
		logic                            pol_issued;
		logic [ctmt_pkg::SRC_BITS-1:0]   pol_en;
		logic [ctmt_pkg::SRC_BITS-1:0]   pol_qual;
		logic [ctmt_pkg::TIME_BITS-1:0]  pol_gen;
		logic                            go;
		logic [ctmt_pkg::MODE_BITS-1:0]  go_mode;
		logic                            go_qual;
		logic                            go_take;
		logic [ctmt_pkg::SRC_BITS-1:0]   eff;
		logic [ctmt_pkg::TIME_BITS-1:0]  gen_inc;
		logic [ctmt_pkg::MODE_BITS-1:0]  rec;
		logic                            neutral;
		logic                            lat;
		logic [ctmt_pkg::COUNT_BITS-1:0] cnt;
		logic [ctmt_pkg::TIME_BITS-1:0]  elapsed;
		logic                            ok;

		nx         = st;
		ev         = ctmt_pkg::EV_NONE;
		acc        = 1'b0;
		pol_issued = 1'b0;
		pol_en     = '0;
		pol_qual   = '0;
		pol_gen    = '0;
		go         = 1'b0;
		go_mode    = ctmt_pkg::M_DISABLED;
		go_qual    = 1'b0;
		go_take    = 1'b0;
		ok         = item.policy_ok;
		gen_inc    = st.generation + ctmt_pkg::TIME_BITS'(1);
		rec        = (st.recovery == ctmt_pkg::M_AUTO || st.recovery == ctmt_pkg::M_LINE)
			? st.recovery : ctmt_pkg::M_DISABLED;
		neutral    = item.sample_ok && (item.stick_level <= cfg.exit_thr) &&
			!item.dpad_pressed && !item.macro_held && !item.macro_pressed_edge;
		elapsed    = item.time_ms - st.neutral_start;
		lat        = st.stick_latch;
		cnt        = st.confirm_count;

		case (item.cmd)
			ctmt_pkg::CMD_SAMPLE: begin
				if (st.mode == ctmt_pkg::M_MANUAL) begin
					if (!item.link_online) begin
						nx.recovery       = ctmt_pkg::M_DISABLED;
						go                = 1'b1;
						go_mode           = ctmt_pkg::M_DISABLED;
						nx.stick_latch    = 1'b0;
						nx.confirm_count  = '0;
						ev                = ctmt_pkg::EV_DISCONNECT;
					end else if (!neutral) begin
						nx.neutral_start  = '0;
						nx.neutral_timing = 1'b0;
					end else if (!st.neutral_timing) begin
						nx.neutral_start  = item.time_ms;
						nx.neutral_timing = 1'b1;
					end else if (elapsed >= ctmt_pkg::TIME_BITS'(cfg.restore_ms)) begin
						// restore the saved mode
						go      = 1'b1;
						go_mode = rec;
						if (ok) begin
							nx.stick_latch   = 1'b0;
							nx.confirm_count = '0;
							ev = (rec == ctmt_pkg::M_LINE) ? ctmt_pkg::EV_RESTORE_LN
								: ctmt_pkg::EV_RESTORE_AU;
						end
					end
				end else if (!item.sample_ok || !item.link_online ||
						(st.mode != ctmt_pkg::M_AUTO && st.mode != ctmt_pkg::M_LINE)) begin
					nx.confirm_count = '0;
				end else begin
					// hysteresis latch on the stick level
					if (item.stick_level >= cfg.enter_thr)
						lat = 1'b1;
					else if (item.stick_level <= cfg.exit_thr)
						lat = 1'b0;
					nx.stick_latch = lat;
					if (item.dpad_pressed || item.macro_pressed_edge) begin
						go = 1'b1;
					end else if (!lat) begin
						nx.confirm_count = '0;
					end else begin
						if (cnt < cfg.confirm)
							cnt = cnt + ctmt_pkg::COUNT_BITS'(1);
						nx.confirm_count = cnt;
						go = (cnt >= cfg.confirm);
					end
					if (go) begin
						nx.recovery = st.mode;
						go_mode     = ctmt_pkg::M_MANUAL;
						go_qual     = 1'b1;
						go_take     = 1'b1;
						if (ok) begin
							nx.stick_latch   = 1'b1;
							nx.confirm_count = '0;
							ev = ctmt_pkg::EV_MANUAL;
						end
					end
				end
			end
			ctmt_pkg::CMD_REQUEST: begin
				if (item.requested_mode > ctmt_pkg::M_MAINT ||
						item.requested_mode == ctmt_pkg::M_MANUAL ||
						st.mode == ctmt_pkg::M_MANUAL) begin
					acc = 1'b0;
				end else if (st.mode == item.requested_mode) begin
					acc = 1'b1;
				end else begin
					nx.recovery = item.requested_mode;
					go          = 1'b1;
					go_mode     = item.requested_mode;
					acc         = ok;
				end
			end
			ctmt_pkg::CMD_CAP: begin
				if (item.new_capability[ctmt_pkg::CAP_BITS-1:ctmt_pkg::SRC_BITS] != '0) begin
					acc = 1'b0;
				end else if (st.capability == item.new_capability[ctmt_pkg::SRC_BITS-1:0]) begin
					acc = 1'b1;
				end else begin
					// mask change is tagged with the current generation
					pol_issued = 1'b1;
					pol_en     = ctmt_pkg::source_of(st.mode) &
						item.new_capability[ctmt_pkg::SRC_BITS-1:0];
					pol_gen    = st.generation;
					acc        = ok;
					if (ok)
						nx.capability = item.new_capability[ctmt_pkg::SRC_BITS-1:0];
				end
			end
			default: ;
		endcase

		// common transition path: issue policy, commit on acceptance
		eff = ctmt_pkg::source_of(go_mode) & st.capability;
		if (go) begin
			nx.neutral_timing = 1'b0;
			pol_issued        = 1'b1;
			pol_en            = eff;
			pol_qual          = {{(ctmt_pkg::SRC_BITS-1){1'b0}}, go_qual} & eff;
			pol_gen           = gen_inc;
			if (ok) begin
				nx.mode          = go_mode;
				nx.generation    = gen_inc;
				nx.takeover      = go_take;
				nx.neutral_start = '0;
			end
		end

		res.event_res           = ev;
		res.accepted            = acc;
		res.current_mode        = nx.mode;
		res.saved_recovery_mode = nx.recovery;
		res.takeover_flag       = nx.takeover;
		res.generation_count    = nx.generation;
		res.policy_issued       = pol_issued;
		res.policy_enable_mask  = pol_en;
		res.policy_qualify_mask = pol_qual;
		res.policy_generation   = pol_gen;
	end

endmodule

// ----- src/control_mode_takeover_coordinator.sv -----
// top level: input register, mode state, decision logic and result register
//
//  channel   handshake                fields
//  input     in_valid / in_ready      cmd .. policy_ok
//  result    out_valid / out_ready    event_res .. policy_generation
//  config    cfg_valid / cfg_ready    cfg_index, cfg_data
//
// one request per cycle while the result side is not stalled; a result passes through the
// input register and then the result register, set by the single decision stage
// reset returns every mode register and configuration register to its default
// a stalled result holds in the result register while the input register keeps
// one more request; both stall only when out_ready stays low
`timescale 1ns / 1ps

module control_mode_takeover_coordinator (
	input  logic                            clk,
	input  logic                            arst_n,

	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [ctmt_pkg::CMD_BITS-1:0]   cmd,
	input  logic                            link_online,
	input  logic                            sample_ok,
	input  logic [ctmt_pkg::STICK_BITS-1:0] stick_level,
	input  logic                            dpad_pressed,
	input  logic                            macro_held,
	input  logic                            macro_pressed_edge,
	input  logic [ctmt_pkg::TIME_BITS-1:0]  time_ms,
	input  logic [ctmt_pkg::MODE_BITS-1:0]  requested_mode,
	input  logic [ctmt_pkg::CAP_BITS-1:0]   new_capability,
	input  logic                            policy_ok,

	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [ctmt_pkg::EV_BITS-1:0]    event_res,
	output logic                            accepted,
	output logic [ctmt_pkg::MODE_BITS-1:0]  current_mode,
	output logic [ctmt_pkg::MODE_BITS-1:0]  saved_recovery_mode,
	output logic                            takeover_flag,
	output logic [ctmt_pkg::TIME_BITS-1:0]  generation_count,
	output logic                            policy_issued,
	output logic [ctmt_pkg::SRC_BITS-1:0]   policy_enable_mask,
	output logic [ctmt_pkg::SRC_BITS-1:0]   policy_qualify_mask,
	output logic [ctmt_pkg::TIME_BITS-1:0]  policy_generation,

	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [ctmt_pkg::IDX_BITS-1:0]   cfg_index,
	input  logic [ctmt_pkg::CFG_BITS-1:0]   cfg_data
);

	ctmt_pkg::cfg_t    cfg;
	ctmt_pkg::item_t   item_s1;
	logic              valid_s1;
	ctmt_pkg::state_t  st_q;
	ctmt_pkg::state_t  st_next;
	ctmt_pkg::result_t res_next;
	ctmt_pkg::result_t res_q;
	logic              out_valid_q;
	logic              adv;

	ctmt_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ctmt_step u_step (
		.cfg  (cfg),
		.st   (st_q),
		.item (item_s1),
		.nx   (st_next),
		.res  (res_next)
	);

	// stage 1 moves on when the result register is free or being emptied
	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.cmd                <= cmd;
			item_s1.link_online        <= link_online;
			item_s1.sample_ok          <= sample_ok;
			item_s1.stick_level        <= stick_level;
			item_s1.dpad_pressed       <= dpad_pressed;
			item_s1.macro_held         <= macro_held;
			item_s1.macro_pressed_edge <= macro_pressed_edge;
			item_s1.time_ms            <= time_ms;
			item_s1.requested_mode     <= requested_mode;
			item_s1.new_capability     <= new_capability;
			item_s1.policy_ok          <= policy_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.mode           <= ctmt_pkg::M_AUTO;
			st_q.recovery       <= ctmt_pkg::M_AUTO;
			st_q.generation     <= ctmt_pkg::TIME_BITS'(1);
			st_q.takeover       <= 1'b0;
			st_q.neutral_start  <= '0;
			st_q.neutral_timing <= 1'b0;
			st_q.stick_latch    <= 1'b0;
			st_q.confirm_count  <= '0;
			st_q.capability     <= '0;
		end else if (adv) begin
			st_q <= st_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_next;
		end
	end

	assign out_valid           = out_valid_q;
	assign event_res           = res_q.event_res;
	assign accepted            = res_q.accepted;
	assign current_mode        = res_q.current_mode;
	assign saved_recovery_mode = res_q.saved_recovery_mode;
	assign takeover_flag       = res_q.takeover_flag;
	assign generation_count    = res_q.generation_count;
	assign policy_issued       = res_q.policy_issued;
	assign policy_enable_mask  = res_q.policy_enable_mask;
	assign policy_qualify_mask = res_q.policy_qualify_mask;
	assign policy_generation   = res_q.policy_generation;

endmodule
